### src/tiny_register_machine_defines.svh
// Assertion macros used by the port checker of the register machine.
`ifndef TINY_REGISTER_MACHINE_DEFINES_SVH
`define TINY_REGISTER_MACHINE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define TRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define TRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define TRM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/trm_pkg.sv
// Shared types, codes and helpers of the register machine.
package trm_pkg;

    localparam int WORD_W     = 16;
    localparam int PC_W       = 9;
    localparam int MSZ_W      = 7;
    localparam int SLOT_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd1;

    typedef enum logic [2:0] {
        OPC_MOVE = 3'd0,
        OPC_MOVI = 3'd1,
        OPC_ADD  = 3'd2,
        OPC_SUBI = 3'd3,
        OPC_JZ   = 3'd4,
        OPC_JMP  = 3'd5,
        OPC_RET  = 3'd6
    } t_opc;

    typedef enum logic [1:0] {
        DIV_IA  = 2'd0,
        DIV_IB  = 2'd1,
        DIV_JT  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     prog_wr;
        logic     data_wr;
        logic     rd_issue;
        logic     rd_latch;
        logic     fetch;
        logic     instr_latch;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_store;
        logic     rd_b;
        logic     rd_a;
        logic     exec;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic run_stop;
        logic div_done;
    } t_status;

    // 8 is 1 modulo 7, so fold three-bit groups
    function automatic logic [2:0] mod7(input logic [WORD_W-1:0] v);
        logic [5:0] s;
        logic [3:0] f;
        s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
            + 6'(v[15]);
        f = 4'(s[5:3]) + 4'(s[2:0]);
        if (f >= 4'd7) begin
            f = f - 4'd7;
        end
        return f[2:0];
    endfunction

endpackage

### src/trm_if.sv
// Channel interfaces: item input, result output and register write.
interface trm_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      op;
    logic [trm_pkg::SLOT_W-1:0]      slot;
    logic [trm_pkg::WORD_W-1:0]      opcode_word;
    logic [trm_pkg::WORD_W-1:0]      operand_a;
    logic [trm_pkg::WORD_W-1:0]      operand_b;
    logic signed [trm_pkg::WORD_W-1:0] data_value;
    logic [trm_pkg::WORD_W-1:0]      step_count;
    modport source (output valid, op, slot, opcode_word, operand_a, operand_b,
                    data_value, step_count, input ready);
    modport sink (input valid, op, slot, opcode_word, operand_a, operand_b,
                  data_value, step_count, output ready);
endinterface

interface trm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [trm_pkg::WORD_W-1:0] read_value;
    logic [trm_pkg::PC_W-1:0]          counter;
    logic                              halted;
    logic                              fault;
    modport source (output valid, read_value, counter, halted, fault, input ready);
    modport sink (input valid, read_value, counter, halted, fault, output ready);
endinterface

interface trm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [trm_pkg::CFG_IDX_W-1:0]     index;
    logic [trm_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/tiny_register_machine.sv
// Top level of the seven-instruction register machine.
// Each input beat yields exactly one result beat, which may wait for the output
// to drain. A run executes one instruction per step: each step fetches the
// instruction, then reduces three operands (two memory indices and the jump
// target) in turn on one bit-serial remainder unit, while the immediate is
// reduced by a constant reciprocal multiply alongside, then reads the two data
// operands and executes, writing back the result of a data instruction. The next
// beat is taken only once the current one has been handed to the output
// register; a pending result does not block it. Register writes are always
// accepted and take effect at once.
module tiny_register_machine #(
    parameter int PROG_DEPTH   = 256,
    parameter int MEM_DEPTH    = 64,
    parameter int WORD_MODULUS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    trm_in_if.sink    i_in,
    trm_out_if.source o_out,
    trm_cfg_if.sink   i_cfg
);
    trm_pkg::t_cmd    cmd;
    trm_pkg::t_status status;
    logic             out_valid;
    logic [trm_pkg::WORD_W-1:0] read_value;

    assign i_cfg.ready = 1'b1;

    trm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    trm_dp #(
        .PROG_DEPTH   (PROG_DEPTH),
        .MEM_DEPTH    (MEM_DEPTH),
        .WORD_MODULUS (WORD_MODULUS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_in.op),
        .i_slot        (i_in.slot),
        .i_opcode_word (i_in.opcode_word),
        .i_operand_a   (i_in.operand_a),
        .i_operand_b   (i_in.operand_b),
        .i_data_value  (i_in.data_value),
        .i_step_count  (i_in.step_count),
        .i_cfg_wr      (i_cfg.valid),
        .i_cfg_idx     (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_read_value  (read_value),
        .o_counter     (o_out.counter),
        .o_halted      (o_out.halted),
        .o_fault       (o_out.fault)
    );

    assign o_out.valid      = out_valid;
    assign o_out.read_value = read_value;
endmodule

### src/trm_div.sv
// Bit-serial remainder unit, one dividend bit per cycle.
module trm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [trm_pkg::WORD_W-1:0]  i_dividend,
    input  logic [trm_pkg::WORD_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [trm_pkg::WORD_W-1:0]  o_rem
);
    localparam int W = trm_pkg::WORD_W;

    logic           r_busy;
    logic           r_done;
    logic [3:0]     r_cnt;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_dvd;
    logic [W-1:0]   r_dvs;
    logic [W:0]     n_trial;
    logic [W:0]     n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[W-1]};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_rem = n_trial - {1'b0, r_dvs};
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem[W-1:0];
            r_dvd <= {r_dvd[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

### src/trm_dp.sv
// Datapath: stores, machine registers, operand reduction and execution.
module trm_dp #(
    parameter int PROG_DEPTH   = 256,
    parameter int MEM_DEPTH    = 64,
    parameter int WORD_MODULUS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  trm_pkg::t_cmd                      i_cmd,
    output trm_pkg::t_status                   o_status,
    input  logic [1:0]                         i_op,
    input  logic [trm_pkg::SLOT_W-1:0]         i_slot,
    input  logic [trm_pkg::WORD_W-1:0]         i_opcode_word,
    input  logic [trm_pkg::WORD_W-1:0]         i_operand_a,
    input  logic [trm_pkg::WORD_W-1:0]         i_operand_b,
    input  logic [trm_pkg::WORD_W-1:0]         i_data_value,
    input  logic [trm_pkg::WORD_W-1:0]         i_step_count,
    input  logic                               i_cfg_wr,
    input  logic [trm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [trm_pkg::WORD_W-1:0]         o_read_value,
    output logic [trm_pkg::PC_W-1:0]           o_counter,
    output logic                               o_halted,
    output logic                               o_fault
);
    localparam int W    = trm_pkg::WORD_W;
    localparam int PCW  = trm_pkg::PC_W;
    localparam int SW   = trm_pkg::SLOT_W;
    localparam int PAW  = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int MAW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PXW  = (PAW > PCW) ? PAW : PCW;
    localparam int SPXW = (PAW > SW) ? PAW : SW;
    localparam int SMXW = (MAW > SW) ? MAW : SW;
    // reciprocal of the word modulus, exact for every 16-bit immediate
    localparam logic [31:0] IMM_RECIP =
        32'(64'h1_0000_0000 / 64'(WORD_MODULUS) + 64'd1);

    logic [3*W-1:0] r_prog [PROG_DEPTH];
    logic [W-1:0]   r_dmem [MEM_DEPTH];

    trm_pkg::t_op   r_op;
    logic [SW-1:0]  r_slot;
    logic [W-1:0]   r_w0, r_w1, r_w2, r_dv, r_n;
    logic [3*W-1:0] r_pq;
    logic [W-1:0]   r_dq;
    trm_pkg::t_opc  r_opc;
    logic [W-1:0]   r_a, r_b, r_imm, r_rb, r_rdv;
    logic [W-1:0]   r_imm_q;
    logic [MAW-1:0] r_ia, r_ib;
    logic [PCW-1:0] r_jt;
    logic [PCW-1:0] r_pc;
    logic           r_halt, r_fault;
    logic [trm_pkg::CFG_DATA_W-1:0] r_plen;
    logic [trm_pkg::MSZ_W-1:0]      r_msize;
    logic [W-1:0]   r_o_rd;
    logic [PCW-1:0] r_o_pc;
    logic           r_o_halt, r_o_fault;

    logic [PCW-1:0]               len;
    logic [trm_pkg::MSZ_W-1:0]    msz;
    logic [PXW-1:0]               pc_ext;
    logic [SPXW-1:0]              slot_p;
    logic [SMXW-1:0]              slot_m;
    logic                         slot_p_ok, slot_m_ok;
    logic [W-1:0]                 div_dvd, div_dvs, div_rem;
    logic                         div_done;
    logic                         dwr_en;
    logic [MAW-1:0]               dwr_addr, drd_addr;
    logic [W-1:0]                 dwr_data;
    logic [W+31:0]                imm_prod;
    logic [31:0]                  imm_qm;

    always_comb begin
        if (32'(r_plen) > PROG_DEPTH) begin
            len = PCW'(PROG_DEPTH);
        end else begin
            len = r_plen;
        end
        if (r_msize == '0) begin
            msz = trm_pkg::MSZ_W'(1);
        end else if (32'(r_msize) > MEM_DEPTH) begin
            msz = trm_pkg::MSZ_W'(MEM_DEPTH);
        end else begin
            msz = r_msize;
        end
    end

    assign pc_ext    = PXW'(r_pc);
    assign slot_p    = SPXW'(r_slot);
    assign slot_m    = SMXW'(r_slot);
    assign slot_p_ok = 32'(r_slot) < PROG_DEPTH;
    assign slot_m_ok = 32'(r_slot) < MEM_DEPTH;

    assign imm_prod = 48'(r_b) * 48'(IMM_RECIP);
    assign imm_qm   = 32'(r_imm_q) * 32'(WORD_MODULUS);

    always_comb begin
        case (i_cmd.div_sel)
            trm_pkg::DIV_IA: begin
                div_dvd = r_a;
                div_dvs = W'(msz);
            end
            trm_pkg::DIV_IB: begin
                div_dvd = r_b;
                div_dvs = W'(msz);
            end
            default: begin
                div_dvd = (r_opc == trm_pkg::OPC_JMP) ? r_a : r_b;
                div_dvs = W'(len);
            end
        endcase
    end

    trm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        dwr_en   = 1'b0;
        dwr_addr = r_ia;
        dwr_data = r_rb;
        if (i_cmd.data_wr) begin
            dwr_en   = slot_m_ok;
            dwr_addr = slot_m[MAW-1:0];
            dwr_data = r_dv;
        end else if (i_cmd.exec) begin
            case (r_opc)
                trm_pkg::OPC_MOVE: begin
                    dwr_en   = 1'b1;
                    dwr_data = r_rb;
                end
                trm_pkg::OPC_MOVI: begin
                    dwr_en   = 1'b1;
                    dwr_data = r_imm;
                end
                trm_pkg::OPC_ADD: begin
                    dwr_en   = 1'b1;
                    dwr_data = r_dq + r_rb;
                end
                trm_pkg::OPC_SUBI: begin
                    dwr_en   = 1'b1;
                    dwr_data = r_dq - r_imm;
                end
                default: begin
                    dwr_en = 1'b0;
                end
            endcase
        end
        if (i_cmd.rd_issue) begin
            drd_addr = slot_m[MAW-1:0];
        end else if (i_cmd.rd_b) begin
            drd_addr = r_ib;
        end else begin
            drd_addr = r_ia;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prog_wr && slot_p_ok) begin
            r_prog[slot_p[PAW-1:0]] <= {r_w0, r_w1, r_w2};
        end
        if (i_cmd.fetch) begin
            r_pq <= r_prog[pc_ext[PAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dwr_en) begin
            r_dmem[dwr_addr] <= dwr_data;
        end
        r_dq <= r_dmem[drd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= trm_pkg::t_op'(i_op);
            r_slot <= i_slot;
            r_w0   <= i_opcode_word;
            r_w1   <= i_operand_a;
            r_w2   <= i_operand_b;
            r_dv   <= i_data_value;
            r_rdv  <= '0;
        end
        if (i_cmd.rd_latch) begin
            r_rdv <= slot_m_ok ? r_dq : '0;
        end
        if (i_cmd.instr_latch) begin
            r_opc <= trm_pkg::t_opc'(trm_pkg::mod7(r_pq[3*W-1:2*W]));
            r_a   <= r_pq[2*W-1:W];
            r_b   <= r_pq[W-1:0];
        end
        // reduce the immediate in two steps while the index reductions run
        r_imm_q <= imm_prod[W+31:32];
        r_imm   <= r_b - imm_qm[W-1:0];
        if (div_done && i_cmd.div_store) begin
            case (i_cmd.div_sel)
                trm_pkg::DIV_IA:  r_ia  <= div_rem[MAW-1:0];
                trm_pkg::DIV_IB:  r_ib  <= div_rem[MAW-1:0];
                default:          r_jt  <= div_rem[PCW-1:0];
            endcase
        end
        if (i_cmd.rd_a) begin
            r_rb <= r_dq;
        end
        if (i_cmd.out_load) begin
            r_o_rd    <= r_rdv;
            r_o_pc    <= r_pc;
            r_o_halt  <= r_halt;
            r_o_fault <= r_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_fault <= 1'b0;
            r_plen  <= '0;
            r_msize <= trm_pkg::MSZ_W'(64);
            r_n     <= '0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_idx)
                    trm_pkg::CFG_PROG_LEN: r_plen  <= i_cfg_data;
                    trm_pkg::CFG_MEM_SIZE: r_msize <= i_cfg_data[trm_pkg::MSZ_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_n <= i_step_count;
            end
            if (i_cmd.exec) begin
                r_n <= r_n - W'(1);
                case (r_opc)
                    trm_pkg::OPC_JZ: begin
                        if (r_dq == '0) begin
                            r_pc <= (len == '0) ? '0 : r_jt;
                        end else begin
                            r_pc <= r_pc + PCW'(1);
                        end
                    end
                    trm_pkg::OPC_JMP: begin
                        if (len == '0) begin
                            r_fault <= 1'b1;
                            r_halt  <= 1'b1;
                        end else begin
                            r_pc <= r_jt;
                        end
                    end
                    trm_pkg::OPC_RET: begin
                        r_halt <= 1'b1;
                    end
                    default: begin
                        r_pc <= r_pc + PCW'(1);
                    end
                endcase
            end
        end
    end

    assign o_status.op       = r_op;
    assign o_status.run_stop = (r_n == '0) || r_halt || (r_pc >= len);
    assign o_status.div_done = div_done;

    assign o_read_value = r_o_rd;
    assign o_counter    = r_o_pc;
    assign o_halted     = r_o_halt;
    assign o_fault      = r_o_fault;
endmodule

### src/trm_ctrl.sv
// Controller: sequences item handling and instruction steps.
module trm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output trm_pkg::t_cmd     o_cmd,
    input  trm_pkg::t_status  i_status
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_CHECK,
        S_FETCH,
        S_DIVGO,
        S_DIVWAIT,
        S_RDB,
        S_RDA,
        S_EXEC,
        S_DONE
    } t_state;

    t_state            r_state;
    logic              r_out_valid;
    trm_pkg::t_div_sel r_sel;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = r_sel;
        case (r_state)
            S_IDLE:     o_cmd.accept = i_in_valid;
            S_DISPATCH: begin
                case (i_status.op)
                    trm_pkg::OP_LOAD:  o_cmd.prog_wr  = 1'b1;
                    trm_pkg::OP_WRITE: o_cmd.data_wr  = 1'b1;
                    trm_pkg::OP_READ:  o_cmd.rd_issue = 1'b1;
                    default: ;
                endcase
            end
            S_READ:     o_cmd.rd_latch    = 1'b1;
            S_CHECK:    o_cmd.fetch       = !i_status.run_stop;
            S_FETCH:    o_cmd.instr_latch = 1'b1;
            S_DIVGO:    o_cmd.div_start   = 1'b1;
            S_DIVWAIT:  o_cmd.div_store   = 1'b1;
            S_RDB:      o_cmd.rd_b        = 1'b1;
            S_RDA:      o_cmd.rd_a        = 1'b1;
            S_EXEC:     o_cmd.exec        = 1'b1;
            S_DONE:     o_cmd.out_load    = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sel       <= trm_pkg::DIV_IA;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (i_status.op)
                        trm_pkg::OP_READ: r_state <= S_READ;
                        trm_pkg::OP_RUN:  r_state <= S_CHECK;
                        default:          r_state <= S_DONE;
                    endcase
                end
                S_READ:  r_state <= S_DONE;
                S_CHECK: begin
                    r_state <= i_status.run_stop ? S_DONE : S_FETCH;
                end
                S_FETCH: begin
                    r_sel   <= trm_pkg::DIV_IA;
                    r_state <= S_DIVGO;
                end
                S_DIVGO: r_state <= S_DIVWAIT;
                S_DIVWAIT: begin
                    if (i_status.div_done) begin
                        if (r_sel == trm_pkg::DIV_JT) begin
                            r_state <= S_RDB;
                        end else begin
                            r_sel   <= trm_pkg::t_div_sel'(r_sel + 2'd1);
                            r_state <= S_DIVGO;
                        end
                    end
                end
                S_RDB:  r_state <= S_RDA;
                S_RDA:  r_state <= S_EXEC;
                S_EXEC: r_state <= S_CHECK;
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

### src/trm_checker.sv
// Port checker for the register machine, bound to the top level.
`include "tiny_register_machine_defines.svh"

module trm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_halted,
    input logic i_out_fault
);
    `TRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `TRM_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)
    `TRM_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `TRM_ASSERT_NOW(a_fault_halts, i_clk, i_rst_n, i_out_valid && i_out_fault, i_out_halted)
    `TRM_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n,
                     i_out_valid && i_out_ready && i_out_halted,
                     !i_out_valid || i_out_halted)
endmodule

bind tiny_register_machine trm_checker u_trm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_halted (o_out.halted),
    .i_out_fault  (o_out.fault)
);

### dv/tiny_register_machine_checker.sv
// Checker: predicts each result beat of the register machine and compares it with the DUT.
module tiny_register_machine_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    trm_in_if    i_in,
    trm_out_if   i_out,
    trm_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    import trm_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [PC_W-1:0]          counter;
        logic                     halted;
        logic                     fault;
    } t_result;

    logic [WORD_W-1:0] prog_words [256][3];
    logic [WORD_W-1:0] data_words [64];
    logic [PC_W-1:0]   pc;
    logic              halt_bit;
    logic              fault_bit;
    logic [PC_W-1:0]   len_reg;
    logic [MSZ_W-1:0]  msz_reg;
    t_result           result_fifo [$];

    assign o_pending = result_fifo.size();

    function automatic int unsigned prog_len();
        return (len_reg > 256) ? 256 : int'(len_reg);
    endfunction

    function automatic int unsigned mem_len();
        if (msz_reg == 0) begin
            return 1;
        end
        return (msz_reg > 64) ? 64 : int'(msz_reg);
    endfunction

    task automatic execute_step(input int unsigned len, input int unsigned msz);
        int unsigned p;
        int unsigned a;
        int unsigned b;
        int unsigned ia;
        int unsigned ib;
        logic [WORD_W-1:0] imm;
        t_opc opc;
        p   = pc % 256;
        opc = t_opc'(prog_words[p][0] % 7);
        a   = prog_words[p][1];
        b   = prog_words[p][2];
        ia  = a % msz;
        ib  = b % msz;
        imm = WORD_W'(b % 256);
        case (opc)
            OPC_MOVE: begin
                data_words[ia] = data_words[ib];
                pc = pc + 1;
            end
            OPC_MOVI: begin
                data_words[ia] = imm;
                pc = pc + 1;
            end
            OPC_ADD: begin
                data_words[ia] = data_words[ia] + data_words[ib];
                pc = pc + 1;
            end
            OPC_SUBI: begin
                data_words[ia] = data_words[ia] - imm;
                pc = pc + 1;
            end
            OPC_JZ: begin
                if (data_words[ia] == 0) begin
                    pc = (len != 0) ? PC_W'(b % len) : '0;
                end else begin
                    pc = pc + 1;
                end
            end
            OPC_JMP: begin
                if (len == 0) begin
                    fault_bit = 1'b1;
                    halt_bit  = 1'b1;
                end else begin
                    pc = PC_W'(a % len);
                end
            end
            default: begin
                halt_bit = 1'b1;
            end
        endcase
    endtask

    task automatic predict_beat();
        t_result r;
        int unsigned len;
        int unsigned msz;
        r = '0;
        case (t_op'(i_in.op))
            OP_LOAD: begin
                prog_words[i_in.slot][0] = i_in.opcode_word;
                prog_words[i_in.slot][1] = i_in.operand_a;
                prog_words[i_in.slot][2] = i_in.operand_b;
            end
            OP_WRITE: begin
                if (i_in.slot < 64) begin
                    data_words[i_in.slot] = i_in.data_value;
                end
            end
            OP_RUN: begin
                len = prog_len();
                msz = mem_len();
                for (int unsigned i = 0; i < i_in.step_count; i++) begin
                    if (halt_bit || pc >= len) begin
                        break;
                    end
                    execute_step(len, msz);
                end
            end
            default: begin
                if (i_in.slot < 64) begin
                    r.read_value = data_words[i_in.slot];
                end
            end
        endcase
        r.counter = pc;
        r.halted  = halt_bit;
        r.fault   = fault_bit;
        result_fifo.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            pc        = '0;
            halt_bit  = 1'b0;
            fault_bit = 1'b0;
            len_reg   = '0;
            msz_reg   = 7'd64;
            o_errors  = 0;
            result_fifo.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_PROG_LEN) begin
                    len_reg = i_cfg.data;
                end else if (i_cfg.index == CFG_MEM_SIZE) begin
                    msz_reg = i_cfg.data[MSZ_W-1:0];
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %0d %0d %0b %0b",
                             $time, i_out.read_value, i_out.counter, i_out.halted,
                             i_out.fault);
                    o_errors++;
                end else begin
                    e = result_fifo.pop_front();
                    if (i_out.read_value !== e.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d", $time,
                                 e.read_value, i_out.read_value);
                        o_errors++;
                    end
                    if (i_out.counter !== e.counter) begin
                        $display("%0t: counter expected %0d actual %0d", $time,
                                 e.counter, i_out.counter);
                        o_errors++;
                    end
                    if (i_out.halted !== e.halted) begin
                        $display("%0t: halted expected %0b actual %0b", $time,
                                 e.halted, i_out.halted);
                        o_errors++;
                    end
                    if (i_out.fault !== e.fault) begin
                        $display("%0t: fault expected %0b actual %0b", $time,
                                 e.fault, i_out.fault);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_beat();
            end
        end
    end
endmodule

### dv/tiny_register_machine_tb.sv
// Testbench top: drives items and register writes into the register machine and gives the verdict.
module tiny_register_machine_tb;
    import trm_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   item_count;
    bit   quiet;
    bit   data_ok [64];
    int unsigned cur_len;
    int unsigned cur_msz;

    trm_in_if  in_ch ();
    trm_out_if out_ch ();
    trm_cfg_if cfg_ch ();

    tiny_register_machine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    tiny_register_machine_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tiny_register_machine_tb: errors");
        $finish;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 32);
    end

    task automatic send_item(input t_op op, input int unsigned slot, input int unsigned ow,
                             input int unsigned a, input int unsigned b,
                             input int unsigned dv, input int unsigned sc);
        while (!quiet && $urandom_range(0, 99) < 32) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.slot        <= SLOT_W'(slot);
        in_ch.opcode_word <= WORD_W'(ow);
        in_ch.operand_a   <= WORD_W'(a);
        in_ch.operand_b   <= WORD_W'(b);
        in_ch.data_value  <= WORD_W'(dv);
        in_ch.step_count  <= WORD_W'(sc);
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        item_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic int unsigned random_opcode();
        int unsigned v;
        v = $urandom_range(0, 65535);
        while (v % 7 == 6 && $urandom_range(0, 39) != 0) begin
            v = $urandom_range(0, 65535);
        end
        return v;
    endfunction

    task automatic fill_data();
        for (int i = 0; i < cur_msz; i++) begin
            if (!data_ok[i]) begin
                send_item(OP_WRITE, i, $urandom, $urandom, $urandom, $urandom, $urandom);
                data_ok[i] = 1'b1;
            end
        end
    endtask

    task automatic load_program();
        int unsigned mult;
        for (int i = 0; i < cur_len; i++) begin
            if (i == cur_len - 1) begin
                mult = $urandom_range(0, 65535 / cur_len);
                send_item(OP_LOAD, i, 7 * $urandom_range(0, 9000) + 5, mult * cur_len,
                          $urandom, $urandom, $urandom);
            end else begin
                send_item(OP_LOAD, i, random_opcode(), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom, $urandom);
            end
        end
    endtask

    task automatic random_item();
        int unsigned slot;
        case ($urandom_range(0, 9))
            0: send_item(OP_LOAD, $urandom_range(0, 255), random_opcode(), $urandom,
                         $urandom, $urandom, $urandom);
            1, 2: begin
                slot = $urandom_range(0, 255);
                if (slot < 64) begin
                    data_ok[slot] = 1'b1;
                end
                send_item(OP_WRITE, slot, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            3, 4, 5: begin
                slot = $urandom_range(0, 255);
                if (slot < 64 && !data_ok[slot]) begin
                    slot = slot | 64;
                end
                send_item(OP_READ, slot, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            default: send_item(OP_RUN, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom_range(0, 20));
        endcase
    endtask

    initial begin
        int unsigned len_val;
        int unsigned msz_val;
        int unsigned pick;
        i_rst_n      = 1'b0;
        quiet        = 1'b0;
        item_count   = 0;
        in_ch.valid  = 1'b0;
        in_ch.op     = OP_LOAD;
        in_ch.slot   = '0;
        in_ch.opcode_word = '0;
        in_ch.operand_a   = '0;
        in_ch.operand_b   = '0;
        in_ch.data_value  = '0;
        in_ch.step_count  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_PROG_LEN;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(OP_READ, 255, 0, 0, 0, 0, 0);
        send_item(OP_WRITE, 200, 0, 0, 0, 16'h7FFF, 0);
        send_item(OP_RUN, 0, 0, 0, 0, 0, 16'hFFFF);
        send_item(OP_WRITE, 0, 0, 0, 0, 16'h8000, 0);
        send_item(OP_WRITE, 1, 0, 0, 0, 16'h7FFF, 0);
        data_ok[0] = 1'b1;
        data_ok[1] = 1'b1;
        send_item(OP_READ, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 1, 0, 0, 0, 0, 0);
        send_item(OP_LOAD, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
        send_item(OP_LOAD, 1, 3, 0, 16'hFFFF, 0, 0);
        send_item(OP_LOAD, 2, 2, 1, 0, 0, 0);
        drain();
        write_reg(CFG_MEM_SIZE, 9'h180);
        write_reg(CFG_PROG_LEN, 3);
        send_item(OP_RUN, 0, 0, 0, 0, 0, 16'hFFFF);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 1, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_MEM_SIZE, 127);
        cur_len = 3;
        cur_msz = 64;

        while (item_count < 650) begin
            drain();
            pick = $urandom_range(0, 29);
            len_val = (pick == 0) ? 0 : (pick == 1) ? 511 : (pick == 2) ? 256
                    : $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            msz_val = (pick == 0) ? 0 : (pick == 1) ? 127 : (pick == 2) ? 64
                    : (pick == 3) ? 1 : $urandom_range(2, 8);
            write_reg(CFG_PROG_LEN, len_val | ($urandom_range(0, 1) << 8 & (len_val == 0 ?
                      0 : 0)));
            write_reg(CFG_MEM_SIZE, msz_val | ($urandom_range(0, 3) << 7));
            cur_len = (len_val > 256) ? 256 : len_val;
            cur_msz = (msz_val == 0) ? 1 : (msz_val > 64) ? 64 : msz_val;
            quiet = (item_count > 300 && item_count < 420);
            fill_data();
            load_program();
            repeat ($urandom_range(10, 30)) begin
                random_item();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tiny_register_machine_tb: clean");
        end else begin
            $display("tiny_register_machine_tb: errors");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+src
src/trm_pkg.sv
src/trm_if.sv
src/trm_div.sv
src/trm_dp.sv
src/trm_ctrl.sv
src/tiny_register_machine.sv
src/trm_checker.sv
dv/tiny_register_machine_checker.sv
dv/tiny_register_machine_tb.sv
